// ===== src/sit_pkg.sv =====
`timescale 1ns / 1ps

package sit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int NUM_SIDES   = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  // Per side: point offset (px, py) from the line origin, and line direction (ex, ey).
  typedef struct packed {
    diff_t px;
    diff_t py;
    diff_t ex;
    diff_t ey;
  } side_diff_t;

  typedef struct packed {
    side_diff_t [NUM_SIDES-1:0] side;
    logic                       box;
  } diff_stage_t;

  typedef struct packed {
    prod_t [NUM_SIDES-1:0] lhs;
    prod_t [NUM_SIDES-1:0] rhs;
    logic                  box;
  } prod_stage_t;

endpackage

// ===== src/sit_diff.sv =====
`timescale 1ns / 1ps

module sit_diff (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  sit_pkg::seg_pair_t    up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output sit_pkg::diff_stage_t  dn_data
);

  logic                 valid_r;
  logic                 valid_nxt;
  sit_pkg::diff_stage_t data_r;
  sit_pkg::diff_stage_t data_nxt;
  logic                 box_x;
  logic                 box_y;

  function automatic sit_pkg::diff_t sub(input sit_pkg::coord_t p, input sit_pkg::coord_t o);
    sub = sit_pkg::diff_t'(p) - sit_pkg::diff_t'(o);
  endfunction

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    // Boxes overlap when some endpoint of each reaches past some endpoint of the other
    box_x = (up_data.a_start_x >= up_data.b_start_x || up_data.a_start_x >= up_data.b_end_x ||
             up_data.a_end_x   >= up_data.b_start_x || up_data.a_end_x   >= up_data.b_end_x) &&
            (up_data.b_start_x >= up_data.a_start_x || up_data.b_start_x >= up_data.a_end_x ||
             up_data.b_end_x   >= up_data.a_start_x || up_data.b_end_x   >= up_data.a_end_x);
    box_y = (up_data.a_start_y >= up_data.b_start_y || up_data.a_start_y >= up_data.b_end_y ||
             up_data.a_end_y   >= up_data.b_start_y || up_data.a_end_y   >= up_data.b_end_y) &&
            (up_data.b_start_y >= up_data.a_start_y || up_data.b_start_y >= up_data.a_end_y ||
             up_data.b_end_y   >= up_data.a_start_y || up_data.b_end_y   >= up_data.a_end_y);
    data_nxt.box = box_x && box_y;

    // B endpoints against line A
    data_nxt.side[0].px = sub(up_data.b_start_x, up_data.a_start_x);
    data_nxt.side[0].py = sub(up_data.b_start_y, up_data.a_start_y);
    data_nxt.side[1].px = sub(up_data.b_end_x,   up_data.a_start_x);
    data_nxt.side[1].py = sub(up_data.b_end_y,   up_data.a_start_y);
    data_nxt.side[0].ex = sub(up_data.a_end_x,   up_data.a_start_x);
    data_nxt.side[0].ey = sub(up_data.a_end_y,   up_data.a_start_y);
    data_nxt.side[1].ex = data_nxt.side[0].ex;
    data_nxt.side[1].ey = data_nxt.side[0].ey;
    // A endpoints against line B
    data_nxt.side[2].px = sub(up_data.a_start_x, up_data.b_start_x);
    data_nxt.side[2].py = sub(up_data.a_start_y, up_data.b_start_y);
    data_nxt.side[3].px = sub(up_data.a_end_x,   up_data.b_start_x);
    data_nxt.side[3].py = sub(up_data.a_end_y,   up_data.b_start_y);
    data_nxt.side[2].ex = sub(up_data.b_end_x,   up_data.b_start_x);
    data_nxt.side[2].ey = sub(up_data.b_end_y,   up_data.b_start_y);
    data_nxt.side[3].ex = data_nxt.side[2].ex;
    data_nxt.side[3].ey = data_nxt.side[2].ey;
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== src/sit_mul.sv =====
`timescale 1ns / 1ps

module sit_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  sit_pkg::diff_stage_t  up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output sit_pkg::prod_stage_t  dn_data
);

  logic                 valid_r;
  logic                 valid_nxt;
  sit_pkg::prod_stage_t data_r;
  sit_pkg::prod_stage_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Cross product terms px*ey and ex*py, one pair per side
  always_comb begin
    data_nxt.box = up_data.box;
    for (int i = 0; i < sit_pkg::NUM_SIDES; i++) begin
      data_nxt.lhs[i] = sit_pkg::prod_t'($signed(up_data.side[i].px)) *
                        sit_pkg::prod_t'($signed(up_data.side[i].ey));
      data_nxt.rhs[i] = sit_pkg::prod_t'($signed(up_data.side[i].ex)) *
                        sit_pkg::prod_t'($signed(up_data.side[i].py));
    end
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== src/sit_sign.sv =====
`timescale 1ns / 1ps

module sit_sign (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  sit_pkg::prod_stage_t  up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic                  dn_hit
);

  logic                              valid_r;
  logic                              valid_nxt;
  logic                              hit_r;
  logic                              hit_nxt;
  sit_pkg::cross_t                   cross_val [sit_pkg::NUM_SIDES];
  logic [sit_pkg::NUM_SIDES-1:0]     pos;
  logic [sit_pkg::NUM_SIDES-1:0]     neg;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    for (int i = 0; i < sit_pkg::NUM_SIDES; i++) begin
      cross_val[i] = sit_pkg::cross_t'($signed(up_data.lhs[i])) -
                     sit_pkg::cross_t'($signed(up_data.rhs[i]));
      neg[i]       = cross_val[i][sit_pkg::CROSS_WIDTH-1];
      pos[i]       = !neg[i] && (cross_val[i] != '0);
    end
    // Same strict side on both endpoints rules out a crossing; zero is a touch
    hit_nxt = up_data.box &&
              !((pos[0] && pos[1]) || (neg[0] && neg[1])) &&
              !((pos[2] && pos[3]) || (neg[2] && neg[3]));
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hit_r <= hit_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_hit   = hit_r;

endmodule

// ===== src/segment_intersection_test.sv =====
`timescale 1ns / 1ps
// A result is offered once its transaction has passed the three-stage pipeline
//   (difference and box test, cross product multipliers, subtract and sign combine).
// Throughput: one transaction per cycle while out_ready is high.
// Reset: rst_n synchronous, active low; clears the stage valid bits only, data holds.
// Each stage takes a new transaction whenever it is empty or its contents move on.

module segment_intersection_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sit_pkg::coord_t     in_a_start_x,
  input  sit_pkg::coord_t     in_a_start_y,
  input  sit_pkg::coord_t     in_a_end_x,
  input  sit_pkg::coord_t     in_a_end_y,
  input  sit_pkg::coord_t     in_b_start_x,
  input  sit_pkg::coord_t     in_b_start_y,
  input  sit_pkg::coord_t     in_b_end_x,
  input  sit_pkg::coord_t     in_b_end_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_intersects
);

  sit_pkg::seg_pair_t   pair;
  sit_pkg::diff_stage_t diff_data;
  sit_pkg::prod_stage_t prod_data;
  logic                 diff_valid;
  logic                 diff_ready;
  logic                 prod_valid;
  logic                 prod_ready;

  // Gather the endpoint coordinates into one bundle for the first stage
  always_comb begin
    pair.a_start_x = in_a_start_x;
    pair.a_start_y = in_a_start_y;
    pair.a_end_x   = in_a_end_x;
    pair.a_end_y   = in_a_end_y;
    pair.b_start_x = in_b_start_x;
    pair.b_start_y = in_b_start_y;
    pair.b_end_x   = in_b_end_x;
    pair.b_end_y   = in_b_end_y;
  end

  // Stage 1: coordinate differences, exact at one bit wider, and bounding box overlap
  sit_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (pair),
    .dn_valid (diff_valid),
    .dn_ready (diff_ready),
    .dn_data  (diff_data)
  );

  // Stage 2: the eight cross product terms, four sides in parallel
  sit_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (diff_valid),
    .up_ready (diff_ready),
    .up_data  (diff_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  // Stage 3: subtract the term pairs, take signs, combine with the box test.
  // Its register is the output register of the block.
  sit_sign u_sign (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_hit   (out_intersects)
  );

endmodule
